/* sv/sprite_motion_animation_engine_defines.svh */
// Assertion macros used by the sprite engine checker.
`ifndef SPRITE_MOTION_ANIMATION_ENGINE_DEFINES_SVH
`define SPRITE_MOTION_ANIMATION_ENGINE_DEFINES_SVH

// Check cons in the same cycle as ante.
`define SMAE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("smae: assertion failed");

// Check cons in the cycle after ante.
`define SMAE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("smae: assertion failed");

`endif

/* sv/smae_pkg.sv */
// Types, constants and codes of the sprite motion and animation engine.
package smae_pkg;

  localparam int unsigned COORD_W  = 16;
  localparam int unsigned DELTA_W  = COORD_W + 1;
  localparam int unsigned ACC_W    = 32;
  localparam int unsigned PROG_W   = ACC_W / 2;
  localparam int unsigned DIST_W   = 15;
  localparam int unsigned SPEED_W  = 24;
  localparam int unsigned FRAME_W  = 8;
  localparam int unsigned PROD_W   = 2 * DELTA_W;
  localparam int unsigned RAD_W    = 34;
  localparam int unsigned ROOT_W   = RAD_W + 1;
  localparam int unsigned DVD_W    = 31;
  localparam int unsigned QUO_W    = DELTA_W;
  localparam int unsigned LANES    = 2;

  localparam int unsigned SQRT_STEPS = 17;
  localparam int unsigned DIV_STEPS  = DVD_W;
  localparam int unsigned CNT_W      = $clog2(DIV_STEPS);

  localparam logic [CNT_W-1:0]  SQRT_LAST = CNT_W'(SQRT_STEPS - 1);
  localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(DIV_STEPS - 1);
  localparam logic [ROOT_W-1:0] SQRT_TOP  = ROOT_W'(64'h1_0000_0000);
  localparam logic [DIST_W-1:0] DIST_MAX  = DIST_W'(32767);

  // APB register map
  localparam int unsigned APB_AW    = 5;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_MOVE_SPEED    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ANIM_SPEED    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_FRAME   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LAST_FRAME    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LOOP_MODE     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_PINGPONG_MODE = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_ANIM_ENABLE   = 3'd6;

  localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(65536);

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_MOVE    = 2'd1,
    CMD_SET_POS = 2'd2,
    CMD_RESTART = 2'd3
  } smae_cmd_e;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LATCH,
    OP_SET_POS,
    OP_RESTART,
    OP_SQ_X,
    OP_SQ_Y,
    OP_SQ_SUM,
    OP_SQRT_STEP,
    OP_SQ_DONE,
    OP_MOVE_ADD,
    OP_MOVE_CHK,
    OP_MUL_Y,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_ANIM,
    OP_PUBLISH
  } smae_op_e;

  typedef struct packed {
    logic [SPEED_W-1:0] move_speed;
    logic [SPEED_W-1:0] anim_speed;
    logic [FRAME_W-1:0] first_frame;
    logic [FRAME_W-1:0] last_frame;
    logic               loop_mode;
    logic               pingpong_mode;
    logic               anim_enable;
  } smae_cfg_t;

  typedef struct packed {
    smae_op_e op;
  } smae_ctl_t;

  typedef struct packed {
    logic move_active;
    logic out_free;
  } smae_sts_t;

endpackage

/* sv/smae_cmd_if.sv */
// Request channel: command and target coordinates.
interface smae_cmd_if;
  import smae_pkg::*;

  logic                      valid;
  logic                      ready;
  smae_cmd_e                 cmd;
  logic signed [COORD_W-1:0] target_x;
  logic signed [COORD_W-1:0] target_y;

  modport source (output valid, output cmd, output target_x, output target_y, input ready);
  modport sink   (input valid, input cmd, input target_x, input target_y, output ready);
endinterface

/* sv/smae_res_if.sv */
// Result channel: sprite position, frame and status flags.
interface smae_res_if;
  import smae_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] frame;
  logic                      moving;
  logic                      anim_running;

  modport source (output valid, output pos_x, output pos_y, output frame, output moving,
                  output anim_running, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input frame, input moving,
                  input anim_running, output ready);
endinterface

/* sv/smae_regs.sv */
// APB configuration register file.
module smae_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [smae_pkg::APB_AW-1:0]  paddr,
  input  logic [smae_pkg::APB_DW-1:0]  pwdata,
  output logic [smae_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output smae_pkg::smae_cfg_t          cfg_o
);
  import smae_pkg::*;

  smae_cfg_t             cfg_q;
  logic                  wr_en;
  logic [REG_IDX_W-1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.move_speed    <= SPEED_RESET;
      cfg_q.anim_speed    <= SPEED_RESET;
      cfg_q.first_frame   <= '0;
      cfg_q.last_frame    <= '0;
      cfg_q.loop_mode     <= 1'b0;
      cfg_q.pingpong_mode <= 1'b0;
      cfg_q.anim_enable   <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MOVE_SPEED:    cfg_q.move_speed    <= pwdata[SPEED_W-1:0];
        REG_ANIM_SPEED:    cfg_q.anim_speed    <= pwdata[SPEED_W-1:0];
        REG_FIRST_FRAME:   cfg_q.first_frame   <= pwdata[FRAME_W-1:0];
        REG_LAST_FRAME:    cfg_q.last_frame    <= pwdata[FRAME_W-1:0];
        REG_LOOP_MODE:     cfg_q.loop_mode     <= pwdata[0];
        REG_PINGPONG_MODE: cfg_q.pingpong_mode <= pwdata[0];
        REG_ANIM_ENABLE:   cfg_q.anim_enable   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MOVE_SPEED:    prdata = APB_DW'(cfg_q.move_speed);
      REG_ANIM_SPEED:    prdata = APB_DW'(cfg_q.anim_speed);
      REG_FIRST_FRAME:   prdata = APB_DW'(cfg_q.first_frame);
      REG_LAST_FRAME:    prdata = APB_DW'(cfg_q.last_frame);
      REG_LOOP_MODE:     prdata = APB_DW'(cfg_q.loop_mode);
      REG_PINGPONG_MODE: prdata = APB_DW'(cfg_q.pingpong_mode);
      REG_ANIM_ENABLE:   prdata = APB_DW'(cfg_q.anim_enable);
      default:           prdata = '0;
    endcase
  end

endmodule

/* sv/smae_ctrl.sv */
// Sequencer: steps the datapath through one request at a time.
module smae_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  smae_pkg::smae_cmd_e  in_cmd_i,
  output logic                 in_ready_o,
  input  smae_pkg::smae_sts_t  sts_i,
  output smae_pkg::smae_ctl_t  ctl_o
);
  import smae_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SET,
    ST_RESTART,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_SUM,
    ST_SQRT,
    ST_SQ_DONE,
    ST_MOVE_ADD,
    ST_MOVE_CHK,
    ST_MUL_Y,
    ST_DIV_START,
    ST_DIV,
    ST_DIV_END,
    ST_ANIM,
    ST_PUBLISH
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ctl_o.op  = OP_NOP;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.op = OP_LATCH;
          unique case (in_cmd_i)
            CMD_TICK:    state_d = ST_MOVE_ADD;
            CMD_MOVE:    state_d = ST_SQ_X;
            CMD_SET_POS: state_d = ST_SET;
            CMD_RESTART: state_d = ST_RESTART;
          endcase
        end
      end
      ST_SET: begin
        ctl_o.op = OP_SET_POS;
        state_d  = ST_PUBLISH;
      end
      ST_RESTART: begin
        ctl_o.op = OP_RESTART;
        state_d  = ST_PUBLISH;
      end
      ST_SQ_X: begin
        ctl_o.op = OP_SQ_X;
        state_d  = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        ctl_o.op = OP_SQ_Y;
        state_d  = ST_SQ_SUM;
      end
      ST_SQ_SUM: begin
        ctl_o.op = OP_SQ_SUM;
        cnt_d    = SQRT_LAST;
        state_d  = ST_SQRT;
      end
      ST_SQRT: begin
        ctl_o.op = OP_SQRT_STEP;
        if (cnt_q == '0) begin
          state_d = ST_SQ_DONE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_SQ_DONE: begin
        ctl_o.op = OP_SQ_DONE;
        state_d  = ST_PUBLISH;
      end
      ST_MOVE_ADD: begin
        // skip the move when already at the goal
        if (sts_i.move_active) begin
          ctl_o.op = OP_MOVE_ADD;
          state_d  = ST_MOVE_CHK;
        end else begin
          state_d = ST_ANIM;
        end
      end
      ST_MOVE_CHK: begin
        ctl_o.op = OP_MOVE_CHK;
        state_d  = sts_i.move_active ? ST_MUL_Y : ST_ANIM;
      end
      ST_MUL_Y: begin
        ctl_o.op = OP_MUL_Y;
        state_d  = ST_DIV_START;
      end
      ST_DIV_START: begin
        ctl_o.op = OP_DIV_START;
        cnt_d    = DIV_LAST;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        ctl_o.op = OP_DIV_STEP;
        if (cnt_q == '0) begin
          state_d = ST_DIV_END;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_DIV_END: begin
        ctl_o.op = OP_DIV_END;
        state_d  = ST_ANIM;
      end
      ST_ANIM: begin
        ctl_o.op = OP_ANIM;
        state_d  = ST_PUBLISH;
      end
      ST_PUBLISH: begin
        // hold until the output register is free
        if (sts_i.out_free) begin
          ctl_o.op = OP_PUBLISH;
          state_d  = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

/* sv/smae_dp.sv */
// Datapath: sprite state, shared multiplier, square root unit, two divider lanes.
module smae_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  smae_pkg::smae_cfg_t                 cfg_i,
  input  smae_pkg::smae_ctl_t                 ctl_i,
  output smae_pkg::smae_sts_t                 sts_o,
  input  logic signed [smae_pkg::COORD_W-1:0] target_x_i,
  input  logic signed [smae_pkg::COORD_W-1:0] target_y_i,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output logic signed [smae_pkg::COORD_W-1:0] pos_x_o,
  output logic signed [smae_pkg::COORD_W-1:0] pos_y_o,
  output logic signed [smae_pkg::COORD_W-1:0] frame_o,
  output logic                                moving_o,
  output logic                                anim_running_o
);
  import smae_pkg::*;

  // architectural state
  logic signed [COORD_W-1:0] cur_x_q, cur_y_q, start_x_q, start_y_q, goal_x_q, goal_y_q;
  logic [ACC_W-1:0]          travel_acc_q;
  logic [DIST_W-1:0]         travel_dist_q;
  logic [ACC_W-1:0]          frame_acc_q;
  logic                      anim_fwd_q;

  // scratch
  logic signed [COORD_W-1:0] tx_q, ty_q;
  logic signed [PROD_W-1:0]  mul_q;
  logic [RAD_W-1:0]          rad_q;
  logic [ROOT_W-1:0]         root_q, bit_q;
  logic [DIST_W-1:0]         div_rem_q [LANES];
  logic [DVD_W-1:0]          div_dvd_q [LANES];
  logic                      div_neg_q [LANES];

  logic                      res_valid_q;
  logic signed [COORD_W-1:0] pos_x_q, pos_y_q, frame_q;
  logic                      moving_q, anim_running_q;

  logic [PROG_W-1:0]         prog;
  logic                      move_active;
  logic signed [DELTA_W-1:0] dx_t, dy_t, gx_s, gy_s;
  logic signed [DELTA_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0]  mul_p, mul_mag;
  logic [ROOT_W-1:0]         root_sum;
  logic                      root_fit;
  logic [DIST_W-1:0]         root_sat;
  logic [DIST_W:0]           div_sh  [LANES];
  logic                      div_fit [LANES];
  logic [DIST_W-1:0]         div_rem_nx [LANES];
  logic [QUO_W-1:0]          quo_mag [LANES];
  logic signed [QUO_W-1:0]   quo_sgn [LANES];
  logic signed [COORD_W-1:0] lane_start [LANES];
  logic signed [COORD_W-1:0] lane_pos [LANES];
  logic [ACC_W-1:0]          anim_step, frame_nx;
  logic                      fwd_nx;
  logic [FRAME_W-1:0]        last_frame;

  assign last_frame  = cfg_i.last_frame;
  assign prog        = travel_acc_q[ACC_W-1:PROG_W];
  assign move_active = prog < PROG_W'(travel_dist_q);

  assign sts_o.move_active = move_active;
  assign sts_o.out_free    = !res_valid_q || res_ready_i;

  assign dx_t = DELTA_W'(tx_q) - DELTA_W'(cur_x_q);
  assign dy_t = DELTA_W'(ty_q) - DELTA_W'(cur_y_q);
  assign gx_s = DELTA_W'(goal_x_q) - DELTA_W'(start_x_q);
  assign gy_s = DELTA_W'(goal_y_q) - DELTA_W'(start_y_q);

  always_comb begin
    unique case (ctl_i.op)
      OP_SQ_X: begin
        mul_a = dx_t;
        mul_b = dx_t;
      end
      OP_SQ_Y: begin
        mul_a = dy_t;
        mul_b = dy_t;
      end
      OP_MOVE_CHK: begin
        mul_a = gx_s;
        mul_b = $signed({1'b0, prog});
      end
      OP_MUL_Y: begin
        mul_a = gy_s;
        mul_b = $signed({1'b0, prog});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign mul_mag = mul_q[PROD_W-1] ? -mul_q : mul_q;

  // one bit of the square root per step
  assign root_sum = root_q + bit_q;
  assign root_fit = root_sum <= ROOT_W'(rad_q);
  assign root_sat = (root_q > ROOT_W'(DIST_MAX)) ? DIST_MAX : root_q[DIST_W-1:0];

  assign lane_start[0] = start_x_q;
  assign lane_start[1] = start_y_q;

  // restoring division, one quotient bit per step on each lane
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      div_sh[l]     = {div_rem_q[l], div_dvd_q[l][DVD_W-1]};
      div_fit[l]    = div_sh[l] >= (DIST_W + 1)'(travel_dist_q);
      div_rem_nx[l] = div_fit[l] ? DIST_W'(div_sh[l] - (DIST_W + 1)'(travel_dist_q))
                                 : div_sh[l][DIST_W-1:0];
      quo_mag[l]    = div_dvd_q[l][QUO_W-1:0];
      quo_sgn[l]    = div_neg_q[l] ? -$signed(quo_mag[l]) : $signed(quo_mag[l]);
      lane_pos[l]   = COORD_W'(QUO_W'(lane_start[l]) + quo_sgn[l]);
    end
  end

  // frame counter step with end handling
  always_comb begin
    anim_step = anim_fwd_q ? frame_acc_q + ACC_W'(cfg_i.anim_speed)
                           : frame_acc_q - ACC_W'(cfg_i.anim_speed);
    frame_nx  = anim_step;
    fwd_nx    = anim_fwd_q;
    if (anim_step[ACC_W-1]) begin
      frame_nx[ACC_W-1:PROG_W] = (cfg_i.pingpong_mode && (last_frame != '0)) ?
                                 PROG_W'(1) : '0;
      fwd_nx = 1'b1;
    end
    if (frame_nx[ACC_W-1:PROG_W] > PROG_W'(last_frame)) begin
      if (cfg_i.loop_mode) begin
        frame_nx[ACC_W-1:PROG_W] = '0;
      end else if (cfg_i.pingpong_mode) begin
        fwd_nx = 1'b0;
        frame_nx[ACC_W-1:PROG_W] = (last_frame != '0) ? PROG_W'(last_frame - 1'b1) : '0;
      end else begin
        frame_nx[ACC_W-1:PROG_W] = PROG_W'(last_frame);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q       <= '0;
      cur_y_q       <= '0;
      start_x_q     <= '0;
      start_y_q     <= '0;
      goal_x_q      <= '0;
      goal_y_q      <= '0;
      travel_acc_q  <= '0;
      travel_dist_q <= '0;
      frame_acc_q   <= '0;
      anim_fwd_q    <= 1'b1;
    end else begin
      unique case (ctl_i.op)
        OP_SET_POS: begin
          cur_x_q       <= tx_q;
          cur_y_q       <= ty_q;
          start_x_q     <= tx_q;
          start_y_q     <= ty_q;
          goal_x_q      <= tx_q;
          goal_y_q      <= ty_q;
          travel_acc_q  <= '0;
          travel_dist_q <= '0;
        end
        OP_RESTART: begin
          frame_acc_q <= {PROG_W'(cfg_i.first_frame), PROG_W'(0)};
          anim_fwd_q  <= 1'b1;
        end
        OP_SQ_X: begin
          start_x_q <= cur_x_q;
          start_y_q <= cur_y_q;
          goal_x_q  <= tx_q;
          goal_y_q  <= ty_q;
        end
        OP_SQ_DONE: begin
          travel_dist_q <= root_sat;
          travel_acc_q  <= '0;
        end
        OP_MOVE_ADD: travel_acc_q <= travel_acc_q + ACC_W'(cfg_i.move_speed);
        OP_MOVE_CHK: begin
          // snap to the goal on arrival
          if (!move_active) begin
            travel_acc_q  <= '0;
            travel_dist_q <= '0;
            cur_x_q       <= goal_x_q;
            cur_y_q       <= goal_y_q;
            start_x_q     <= goal_x_q;
            start_y_q     <= goal_y_q;
          end
        end
        OP_DIV_END: begin
          cur_x_q <= lane_pos[0];
          cur_y_q <= lane_pos[1];
        end
        OP_ANIM: begin
          if (cfg_i.anim_enable) begin
            frame_acc_q <= frame_nx;
            anim_fwd_q  <= fwd_nx;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctl_i.op)
      OP_LATCH: begin
        tx_q <= target_x_i;
        ty_q <= target_y_i;
      end
      OP_SQ_X: mul_q <= mul_p;
      OP_SQ_Y: begin
        rad_q <= RAD_W'($unsigned(mul_q));
        mul_q <= mul_p;
      end
      OP_SQ_SUM: begin
        rad_q  <= rad_q + RAD_W'($unsigned(mul_q));
        root_q <= '0;
        bit_q  <= SQRT_TOP;
      end
      OP_SQRT_STEP: begin
        if (root_fit) begin
          rad_q  <= rad_q - root_sum[RAD_W-1:0];
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      OP_MOVE_CHK: mul_q <= mul_p;
      OP_MUL_Y: begin
        div_neg_q[0] <= mul_q[PROD_W-1];
        div_dvd_q[0] <= mul_mag[DVD_W-1:0];
        div_rem_q[0] <= '0;
        mul_q        <= mul_p;
      end
      OP_DIV_START: begin
        div_neg_q[1] <= mul_q[PROD_W-1];
        div_dvd_q[1] <= mul_mag[DVD_W-1:0];
        div_rem_q[1] <= '0;
      end
      OP_DIV_STEP: begin
        for (int l = 0; l < LANES; l++) begin
          div_rem_q[l] <= div_rem_nx[l];
          div_dvd_q[l] <= {div_dvd_q[l][DVD_W-2:0], div_fit[l]};
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (ctl_i.op == OP_PUBLISH) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.op == OP_PUBLISH) begin
      pos_x_q        <= cur_x_q;
      pos_y_q        <= cur_y_q;
      frame_q        <= $signed(frame_acc_q[ACC_W-1:PROG_W]);
      moving_q       <= move_active;
      anim_running_q <= frame_acc_q[ACC_W-1:PROG_W] != PROG_W'(last_frame);
    end
  end

  assign res_valid_o    = res_valid_q;
  assign pos_x_o        = pos_x_q;
  assign pos_y_o        = pos_y_q;
  assign frame_o        = frame_q;
  assign moving_o       = moving_q;
  assign anim_running_o = anim_running_q;

endmodule

/* sv/sprite_motion_animation_engine.sv */
// Top level of the sprite motion and animation engine.
//
// Requests arrive on cmd_ch (valid/ready): tick, move to target, set position,
// restart animation. Each request produces exactly one result on res_ch with
// the sprite position, the integer frame and the moving/anim_running flags.
// The user must write registers over the APB port only while the engine is idle;
// the block itself does not enforce this. One request is in work at a time;
// cmd_ch.ready is high only when idle. Move to target runs the 17-step square
// root unit; a tick while moving runs the 31-step divider, x and y lanes in
// parallel; a tick that arrives or finds the sprite at rest skips the divider.
// The next request can be taken in the cycle after a result is published.
// The output register holds a finished result until res_ch.ready; the next
// request is accepted meanwhile, and its result waits for the register.
// Reset clears position, travel and frame state, sets the direction forward
// and loads the register defaults.
module sprite_motion_animation_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  smae_cmd_if.sink                     cmd_ch,
  smae_res_if.source                   res_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [smae_pkg::APB_AW-1:0]  paddr,
  input  logic [smae_pkg::APB_DW-1:0]  pwdata,
  output logic [smae_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import smae_pkg::*;

  smae_cfg_t cfg;
  smae_ctl_t ctl;
  smae_sts_t sts;

  smae_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  smae_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_ch.valid),
    .in_cmd_i   (cmd_ch.cmd),
    .in_ready_o (cmd_ch.ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  smae_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .target_x_i     (cmd_ch.target_x),
    .target_y_i     (cmd_ch.target_y),
    .res_valid_o    (res_ch.valid),
    .res_ready_i    (res_ch.ready),
    .pos_x_o        (res_ch.pos_x),
    .pos_y_o        (res_ch.pos_y),
    .frame_o        (res_ch.frame),
    .moving_o       (res_ch.moving),
    .anim_running_o (res_ch.anim_running)
  );

endmodule

/* sv/smae_checker.sv */
// Port-level checker for the sprite engine and its bind to the top level.
`include "sprite_motion_animation_engine_defines.svh"

module smae_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_i,
  input logic                                res_valid_i,
  input logic                                res_ready_i,
  input logic signed [smae_pkg::COORD_W-1:0] pos_x_i,
  input logic signed [smae_pkg::COORD_W-1:0] pos_y_i,
  input logic signed [smae_pkg::COORD_W-1:0] frame_i,
  input logic                                moving_i,
  input logic                                anim_running_i
);
  import smae_pkg::*;

  logic [1:0] pending_q;
  logic       in_fire, res_fire;

  assign in_fire  = in_valid_i && in_ready_i;
  assign res_fire = res_valid_i && res_ready_i;

  // requests accepted whose result has not been taken yet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 2'(in_fire) - 2'(res_fire);
    end
  end

  `SMAE_ASSERT_NEXT(a_one_in_work, in_fire, !in_ready_i)
  `SMAE_ASSERT_NOW(a_no_orphan_result, res_valid_i, pending_q != 2'd0)
  `SMAE_ASSERT_NOW(a_max_in_flight, in_fire, pending_q == 2'd0 || pending_q == 2'd1)
  `SMAE_ASSERT_NEXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i && $stable(pos_x_i) && $stable(pos_y_i) && $stable(frame_i) && $stable(moving_i) && $stable(anim_running_i))

endmodule

bind sprite_motion_animation_engine smae_checker u_smae_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (cmd_ch.valid),
  .in_ready_i     (cmd_ch.ready),
  .res_valid_i    (res_ch.valid),
  .res_ready_i    (res_ch.ready),
  .pos_x_i        (res_ch.pos_x),
  .pos_y_i        (res_ch.pos_y),
  .frame_i        (res_ch.frame),
  .moving_i       (res_ch.moving),
  .anim_running_i (res_ch.anim_running)
);
